### src/apci_pkg.sv
// Shared types and constants for the IEC 104 APCI link receiver.
// No dependencies; imported by apci_core and the top level.
`default_nettype none

package apci_pkg;

   localparam int SEQ_W = 15;

   // Item opcodes
   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_HEADER = 2'd2;

   // Event codes
   localparam logic [1:0] EV_FRAME  = 2'd0;
   localparam logic [1:0] EV_DROP   = 2'd1;
   localparam logic [1:0] EV_HEADER = 2'd2;

   // Frame kinds
   localparam logic [1:0] KIND_I     = 2'd0;
   localparam logic [1:0] KIND_S     = 2'd1;
   localparam logic [1:0] KIND_U     = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_MAX_LENGTH    = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;

   localparam logic [7:0]  MAX_LENGTH_RST = 8'd253;
   localparam logic [15:0] TIMEOUT_RST    = 16'd200;

   localparam logic [7:0] START_BYTE   = 8'h68;
   localparam logic [7:0] CTRL_S       = 8'h01;
   localparam logic [7:0] CTRL_LEN     = 8'h04;
   localparam logic [7:0] U_STARTDT    = 8'h07;
   localparam logic [7:0] U_STARTDT_CN = 8'h0B;
   localparam logic [7:0] U_TESTFR     = 8'h43;
   localparam logic [7:0] U_TESTFR_CN  = 8'h83;
   localparam logic [7:0] HDR_EXTRA    = 8'd4;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic [7:0] payload_length;
   } item_type;

   typedef struct packed {
      logic [7:0]  max_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       event_res;
      logic [1:0]       frame_kind;
      logic [SEQ_W-1:0] peer_send_seq;
      logic [SEQ_W-1:0] peer_recv_seq;
      logic             reply_valid;
      logic [7:0]       reply_control;
      logic [7:0]       header_length;
      logic [SEQ_W-1:0] header_send_seq;
      logic [SEQ_W-1:0] header_recv_seq;
      logic             connected;
   } rsp_type;

endpackage

`default_nettype wire

### src/iec104_apci_link_receiver_top.sv
// Top level of the IEC 104 APCI link receiver: input register, result register, CSRs.
// Depends on apci_pkg and apci_core.
//
//   channel  | ports                     | handshake
//   ---------+---------------------------+--------------------
//   request  | req_opcode/data/payload   | req_valid, req_stall
//   result   | rsp_* fields              | rsp_valid, rsp_stall
//   config   | csr_index, csr_wdata      | csr_valid, csr_ready
//
// One beat per cycle while req_stall is low; a request beat goes into the input register,
// then through one pass of the parser into the result register.
// Sync reset clears parser state, sequences and link flag, and loads the CSRs (253 / 200).
// A stalled result holds; requests that give no result keep flowing past it,
// and a request that gives one waits in the input register.
`default_nettype none

module iec104_apci_link_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_payload_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_res,
   output logic [1:0]       rsp_frame_kind,
   output logic [14:0]      rsp_peer_send_seq,
   output logic [14:0]      rsp_peer_recv_seq,
   output logic             rsp_reply_valid,
   output logic [7:0]       rsp_reply_control,
   output logic [7:0]       rsp_header_length,
   output logic [14:0]      rsp_header_send_seq,
   output logic [14:0]      rsp_header_recv_seq,
   output logic             rsp_connected,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import apci_pkg::*;

   logic     in_vld_ff, in_vld_in;
   item_type item_ff;
   logic     rsp_vld_ff, rsp_vld_in;
   rsp_type  rsp_ff;
   cfg_type  cfg_ff;

   logic     accept;
   logic     adv;
   logic     core_valid;
   rsp_type  core_res;

   apci_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (adv),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   assign adv        = in_vld_ff && (!rsp_vld_ff || !rsp_stall || !core_valid);
   assign req_stall  = in_vld_ff && !adv;
   assign accept     = req_valid && !req_stall;
   assign in_vld_in  = accept || (in_vld_ff && !adv);
   assign rsp_vld_in = (adv && core_valid) || (rsp_vld_ff && rsp_stall);
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode         <= req_opcode;
         item_ff.data_byte      <= req_data_byte;
         item_ff.payload_length <= req_payload_length;
      end
      if (adv && core_valid) begin
         rsp_ff <= core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length    <= MAX_LENGTH_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_LENGTH:    cfg_ff.max_length    <= csr_wdata[7:0];
            REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_event_res       = rsp_ff.event_res;
   assign rsp_frame_kind      = rsp_ff.frame_kind;
   assign rsp_peer_send_seq   = rsp_ff.peer_send_seq;
   assign rsp_peer_recv_seq   = rsp_ff.peer_recv_seq;
   assign rsp_reply_valid     = rsp_ff.reply_valid;
   assign rsp_reply_control   = rsp_ff.reply_control;
   assign rsp_header_length   = rsp_ff.header_length;
   assign rsp_header_send_seq = rsp_ff.header_send_seq;
   assign rsp_header_recv_seq = rsp_ff.header_recv_seq;
   assign rsp_connected       = rsp_ff.connected;

endmodule

`default_nettype wire

### src/apci_core.sv
// Frame parser and sequence state for the APCI link receiver.
// Depends on apci_pkg. One item is applied per fire; result is combinational.
`default_nettype none

module apci_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire apci_pkg::item_type item,
   input  wire apci_pkg::cfg_type  cfg,
   output logic                  res_valid,
   output apci_pkg::rsp_type     res
);
   import apci_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       flen_ff, flen_in;
   logic [7:0]       bcnt_ff, bcnt_in;
   logic [15:0]      wait_ff, wait_in;
   logic [SEQ_W-1:0] send_ff, send_in;
   logic [SEQ_W-1:0] recv_ff, recv_in;
   logic             link_ff, link_in;
   logic [7:0]       cb_ff [4];

   logic             wr_en;
   logic             do_drop;
   logic             do_finish;
   logic [8:0]       bcnt_next;
   logic [7:0]       cbv [4];
   logic [SEQ_W-1:0] ns, nr;

   assign bcnt_next = {1'b0, bcnt_ff} + 9'd1;

   // body bytes up to the fourth land in the control field
   assign wr_en = (item.opcode == OP_BYTE) && (phase_ff == PH_BODY) && (bcnt_ff < 8'd4);

   // control bytes as seen with this beat's write applied
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cbv[i] = (wr_en && bcnt_ff[1:0] == 2'(i)) ? item.data_byte : cb_ff[i];
      end
   end

   assign ns = {cbv[1], cbv[0][7:1]};
   assign nr = {cbv[3], cbv[2][7:1]};

   always_comb begin
      phase_in  = phase_ff;
      flen_in   = flen_ff;
      bcnt_in   = bcnt_ff;
      wait_in   = wait_ff;
      send_in   = send_ff;
      recv_in   = recv_ff;
      link_in   = link_ff;
      do_drop   = 1'b0;
      do_finish = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      unique case (item.opcode)
         OP_BYTE: begin
            wait_in = '0;
            unique case (phase_ff)
               PH_LEN: begin
                  flen_in = item.data_byte;
                  bcnt_in = '0;
                  // zero length is a short frame: dropped right away
                  if (item.data_byte > cfg.max_length || item.data_byte == 8'd0) begin
                     do_drop = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  bcnt_in = bcnt_next[7:0];
                  if (bcnt_next >= {1'b0, flen_ff}) begin
                     if (flen_ff < 8'd4) do_drop = 1'b1;
                     else do_finish = 1'b1;
                  end
               end
               default: begin
                  phase_in = (item.data_byte == START_BYTE) ? PH_LEN : PH_IDLE;
               end
            endcase
         end
         OP_TICK: begin
            if (phase_ff == PH_LEN || phase_ff == PH_BODY) begin
               if (wait_ff >= cfg.timeout_ticks) begin
                  wait_in = '0;
                  do_drop = 1'b1;
               end else begin
                  wait_in = wait_ff + 16'd1;
               end
            end
         end
         OP_HEADER: begin
            res_valid           = 1'b1;
            res.event_res       = EV_HEADER;
            res.header_length   = item.payload_length + HDR_EXTRA;
            res.header_send_seq = send_ff;
            res.header_recv_seq = recv_ff;
            send_in             = send_ff + SEQ_W'(1);
         end
         default: ;
      endcase

      if (do_drop) begin
         phase_in      = PH_IDLE;
         res_valid     = 1'b1;
         res.event_res = EV_DROP;
      end

      if (do_finish) begin
         phase_in      = PH_IDLE;
         res_valid     = 1'b1;
         res.event_res = EV_FRAME;
         if (!cbv[0][0]) begin
            res.frame_kind    = KIND_I;
            res.peer_send_seq = ns;
            res.peer_recv_seq = nr;
            recv_in           = ns + SEQ_W'(1);
            send_in           = nr;
         end else if (cbv[0] == CTRL_S) begin
            res.frame_kind    = KIND_S;
            res.peer_recv_seq = nr;
            send_in           = nr;
         end else if (flen_ff == CTRL_LEN) begin
            res.frame_kind = KIND_U;
            if (cbv[0] == U_STARTDT) begin
               link_in           = 1'b1;
               res.reply_valid   = 1'b1;
               res.reply_control = U_STARTDT_CN;
            end else if (cbv[0] == U_TESTFR) begin
               res.reply_valid   = 1'b1;
               res.reply_control = U_TESTFR_CN;
            end
         end else begin
            res.frame_kind = KIND_OTHER;
         end
      end

      res.connected = link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flen_ff  <= '0;
         bcnt_ff  <= '0;
         wait_ff  <= '0;
         send_ff  <= '0;
         recv_ff  <= '0;
         link_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         flen_ff  <= flen_in;
         bcnt_ff  <= bcnt_in;
         wait_ff  <= wait_in;
         send_ff  <= send_in;
         recv_ff  <= recv_in;
         link_ff  <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         cb_ff[bcnt_ff[1:0]] <= item.data_byte;
      end
   end

endmodule

`default_nettype wire
